/* rtl/min_heap_priority_queue_top_macros.svh */
// Assertion macros for the min-heap priority queue.
`ifndef MIN_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH
`define MIN_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH

`ifndef SYNTH
// Check prop at every clock edge outside reset.
`define MHPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Check prop at every clock edge, reset included.
`define MHPQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define MHPQ_ASSERT(lbl, prop, msg)
`define MHPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/mhpq_pkg.sv */
// Package: types, constants and key compare of the min-heap priority queue.
package mhpq_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = ADDR_W + 2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [1:0] ST_PUSH_FULL = 2'd2;

    localparam logic KEY_TIME = 1'b0;

    typedef struct packed {
        logic        opcode;
        logic [15:0] process_id;
        logic [15:0] remaining_time;
        logic [7:0]  priority_req;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        empty_res;
        logic [6:0]  count;
        logic [15:0] min_id;
        logic [15:0] min_remaining_time;
        logic [7:0]  min_priority;
    } t_out_item;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] rem;
        logic [7:0]  prio;
    } t_entry;

    // strict less-than on the selected key
    function automatic logic key_less(t_entry a, t_entry b, logic key_sel);
        logic res;
        if (key_sel == KEY_TIME) begin
            res = a.rem < b.rem;
        end else begin
            res = a.prio < b.prio;
        end
        return res;
    endfunction

endpackage

/* rtl/min_heap_priority_queue_top.sv */
// Top level: binary min-heap priority queue with a sequenced sift unit.
// Items are handled one at a time; a new item is taken only once the sequencer is back in idle.
// Each level costs a registered heap read (both children when sifting down), key compares and one heap write.
// Reset (synchronous, active low) empties the heap and selects remaining time as key;
// the heap store itself is not cleared, only entries below the count are ever used.
module min_heap_priority_queue_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mhpq_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mhpq_pkg::t_out_item o_out_item
);

    `include "min_heap_priority_queue_top_macros.svh"

    // Sequencer states: sift up walks UP_CHK/UP_CMP, sift down walks DN_RD/DN_CMP.
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_UP_CHK = 7'b0000010,
        S_UP_CMP = 7'b0000100,
        S_POP_LD = 7'b0001000,
        S_DN_RD  = 7'b0010000,
        S_DN_CMP = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    // Heap store: one write port, two registered read ports.
    mhpq_pkg::t_entry mem [mhpq_pkg::CAPACITY];

    t_state                          r_state, n_state;
    logic [mhpq_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic [mhpq_pkg::ADDR_W-1:0]     r_idx, n_idx;
    mhpq_pkg::t_entry                r_x, n_x;
    logic [1:0]                      r_status, n_status;
    logic                            r_key;
    mhpq_pkg::t_entry                r_root;
    mhpq_pkg::t_entry                r_rd0, r_rd1;
    logic                            r_out_valid;
    mhpq_pkg::t_out_item             r_out_item;

    logic                            w_we;
    logic [mhpq_pkg::ADDR_W-1:0]     w_addr;
    mhpq_pkg::t_entry                w_data;
    logic [mhpq_pkg::ADDR_W-1:0]     ra0, ra1;

    logic                            in_acc;
    logic                            out_acc;
    logic                            out_load;
    logic [mhpq_pkg::ADDR_W-1:0]     parent;
    logic [mhpq_pkg::CHILD_W-1:0]    left_c, right_c, cnt_ext;
    logic                            l_ok, r_ok, l_less, r_less;
    mhpq_pkg::t_entry                best_e;
    mhpq_pkg::t_entry                in_entry;
    logic                            heap_empty;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = r_out_valid && !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    assign in_entry.id   = i_in_item.process_id;
    assign in_entry.rem  = i_in_item.remaining_time;
    assign in_entry.prio = i_in_item.priority_req;

    // Child and parent positions of the current hole.
    assign parent  = (r_idx - 1'b1) >> 1;
    assign left_c  = {1'b0, r_idx, 1'b1};
    assign right_c = left_c + 1'b1;
    assign cnt_ext = mhpq_pkg::CHILD_W'(r_cnt);
    assign l_ok    = left_c < cnt_ext;
    assign r_ok    = right_c < cnt_ext;

    // Sift-down compare: left wins ties, right must be strictly smaller than the best so far.
    assign l_less = l_ok && mhpq_pkg::key_less(r_rd0, r_x, r_key);
    assign best_e = l_less ? r_rd0 : r_x;
    assign r_less = r_ok && mhpq_pkg::key_less(r_rd1, best_e, r_key);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_x      = r_x;
        n_status = r_status;
        w_we     = 1'b0;
        w_addr   = r_idx;
        w_data   = r_x;
        ra0      = r_idx;
        ra1      = r_idx;
        out_load = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_status = mhpq_pkg::ST_DONE;
                    if (i_in_item.opcode == mhpq_pkg::OP_PUSH) begin
                        if (r_cnt == mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY)) begin
                            // full: drop the entry
                            n_status = mhpq_pkg::ST_PUSH_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_x     = in_entry;
                            n_idx   = mhpq_pkg::ADDR_W'(r_cnt);
                            n_state = S_UP_CHK;
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            n_status = mhpq_pkg::ST_POP_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            // fetch the last entry, it becomes the moving entry
                            n_cnt   = r_cnt - 1'b1;
                            ra0     = mhpq_pkg::ADDR_W'(r_cnt - 1'b1);
                            n_state = (r_cnt == mhpq_pkg::CNT_W'(1)) ? S_DONE : S_POP_LD;
                        end
                    end
                end
            end
            S_UP_CHK: begin
                if (r_idx == '0) begin
                    w_we    = 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_DONE;
                end else begin
                    ra0     = parent;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                w_we = 1'b1;
                if (mhpq_pkg::key_less(r_x, r_rd0, r_key)) begin
                    // move the parent down into the hole
                    w_data  = r_rd0;
                    n_idx   = parent;
                    n_state = S_UP_CHK;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_DONE;
                end
            end
            S_POP_LD: begin
                n_x     = r_rd0;
                n_idx   = '0;
                n_state = S_DN_RD;
            end
            S_DN_RD: begin
                if (!l_ok) begin
                    w_we    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    ra0     = left_c[mhpq_pkg::ADDR_W-1:0];
                    ra1     = right_c[mhpq_pkg::ADDR_W-1:0];
                    n_state = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                w_we = 1'b1;
                if (r_less) begin
                    w_data  = r_rd1;
                    n_idx   = right_c[mhpq_pkg::ADDR_W-1:0];
                    n_state = S_DN_RD;
                end else if (l_less) begin
                    w_data  = r_rd0;
                    n_idx   = left_c[mhpq_pkg::ADDR_W-1:0];
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_key       <= mhpq_pkg::KEY_TIME;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                r_key <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers and heap store.
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_x      <= n_x;
        r_status <= n_status;
        r_rd0    <= mem[ra0];
        r_rd1    <= mem[ra1];
        if (w_we) begin
            mem[w_addr] <= w_data;
            // keep a copy of the root for the result
            if (w_addr == '0) begin
                r_root <= w_data;
            end
        end
    end

    assign heap_empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_item.status             <= r_status;
            r_out_item.empty_res          <= heap_empty;
            r_out_item.count              <= 7'(r_cnt);
            r_out_item.min_id             <= heap_empty ? 16'd0 : r_root.id;
            r_out_item.min_remaining_time <= heap_empty ? 16'd0 : r_root.rem;
            r_out_item.min_priority       <= heap_empty ? 8'd0 : r_root.prio;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Checks on the sequencer and the heap bounds.
    `MHPQ_ASSERT(a_cnt_cap, r_cnt <= mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY), "count above capacity")
    `MHPQ_ASSERT(a_wr_bound, w_we |-> (mhpq_pkg::CNT_W'(w_addr) <= r_cnt), "write beyond heap end")
    `MHPQ_ASSERT(a_busy_after_acc, in_acc |=> (r_state != S_IDLE), "item accepted but no work")
    `MHPQ_ASSERT(a_done_loads, (r_state == S_DONE && !r_out_valid) |=> r_out_valid, "result lost")

endmodule
